// ===== rtl/core/tme_pkg.sv =====
package tme_pkg;

    localparam int MAX_DIM   = 16;
    localparam int FRAC_BITS = 16;
    localparam int IW        = $clog2(MAX_DIM);
    localparam int AW        = 2 * IW;
    localparam int DEPTH     = MAX_DIM * MAX_DIM;
    localparam int SIZE_W    = 5;

    localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(MAX_DIM);

    localparam logic [1:0] CMD_WRITE_A = 2'd0;
    localparam logic [1:0] CMD_WRITE_B = 2'd1;
    localparam logic [1:0] CMD_COMPUTE = 2'd2;
    localparam logic [1:0] CMD_READ_C  = 2'd3;

    localparam logic RES_DONE = 1'b0;
    localparam logic RES_READ = 1'b1;

    // register index, taken from paddr[2]
    localparam logic REG_SIZE = 1'b0;

    typedef struct packed {
        logic [1:0]         command;
        logic [3:0]         row;
        logic [3:0]         col;
        logic signed [31:0] element_value;
    } t_item;

    typedef struct packed {
        logic               result_kind;
        logic signed [31:0] c_value;
        logic               overflow_seen;
    } t_result;

    typedef enum logic [1:0] {
        KIND_SQ,
        KIND_BA,
        KIND_AAB
    } t_kind;

    typedef struct packed {
        logic          valid;
        logic          first;
        logic          last;
        t_kind         kind;
        logic [IW-1:0] i;
        logic [IW-1:0] j;
    } t_tag;

    function automatic logic [AW-1:0] cell_addr(input logic [IW-1:0] r,
                                                input logic [IW-1:0] c);
        return {r, c};
    endfunction

    function automatic logic ovf33(input logic signed [32:0] v);
        return v[32] != v[31];
    endfunction

    function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
        logic signed [31:0] res;
        res = v[31:0];
        if (v[32] != v[31]) begin
            res = v[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end
        return res;
    endfunction

endpackage

// ===== rtl/core/tme_mac.sv =====
module tme_mac (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic signed [31:0]  i_x,
    input  logic signed [31:0]  i_y,
    input  tme_pkg::t_tag       i_tag,
    output logic signed [31:0]  o_acc,
    output tme_pkg::t_tag       o_tag,
    output logic                o_ovf
);

    logic signed [63:0] r_prod;
    tme_pkg::t_tag      r_tag2;
    logic signed [31:0] r_sp;
    logic               r_sp_ovf;
    tme_pkg::t_tag      r_tag3;
    logic signed [31:0] r_acc;
    tme_pkg::t_tag      r_tag4;
    logic               r_ovf;

    logic signed [63:0] sh;
    logic               sh_ovf;
    logic signed [31:0] base;
    logic signed [32:0] sum;

    // floor shift, then clamp to 32 bits
    assign sh     = r_prod >>> tme_pkg::FRAC_BITS;
    assign sh_ovf = sh[63:31] != {33{sh[63]}};
    assign base   = r_tag3.first ? 32'sd0 : r_acc;
    assign sum    = {base[31], base} + {r_sp[31], r_sp};

    always_ff @(posedge i_clk) begin
        r_prod <= i_x * i_y;
        r_sp   <= sh_ovf ? (sh[63] ? 32'sh8000_0000 : 32'sh7FFF_FFFF) : sh[31:0];
        r_sp_ovf <= sh_ovf;
        r_acc  <= tme_pkg::sat33(sum);
        if (!i_rst_n) begin
            r_tag2 <= '0;
            r_tag3 <= '0;
            r_tag4 <= '0;
            r_ovf  <= 1'b0;
        end else begin
            r_tag2 <= i_tag;
            r_tag3 <= r_tag2;
            r_tag4 <= r_tag3;
            r_ovf  <= r_tag3.valid & (r_sp_ovf | tme_pkg::ovf33(sum));
        end
    end

    assign o_acc = r_acc;
    assign o_tag = r_tag4;
    assign o_ovf = r_ovf;

endmodule

// ===== rtl/core/triangular_matrix_expression.sv =====
// Triangular matrix expression unit: C = B*A' + A*A*B over the leading N x N
// block, A taken as upper triangular, all values signed Q16.16.
// Command channel: an item transfers at a rising edge with start high and
// busy low. Write-A and write-B commands store one element and
// give no result. A read-C command returns the element on the result ports
// in the next cycle, marked by o_strobe, and busy stays low. A compute
// command raises busy, walks the terms through one shared multiply,
// scale-and-clamp, accumulate unit and then gives one completion result.
// A compute holds busy while it walks T = N(N+1)(N+2)/6 + N*N*(N+1)
// terms at one per cycle and through two drains of the term pipeline;
// the completion strobe follows in the next cycle.
// Results are shown for exactly one cycle; the receiver cannot stall them.
// Configuration: APB register 0 (byte address 0) holds size_in_use, reset
// value 16. Reset clears control state and the overflow flag; matrix stores
// are not cleared, so a read of C before any compute returns junk.
module triangular_matrix_expression (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  tme_pkg::t_item      i_item,
    output logic                o_strobe,
    output tme_pkg::t_result    o_result,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    localparam int IW = tme_pkg::IW;
    localparam int AW = tme_pkg::AW;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SQ,
        S_DRAIN1,
        S_CB,
        S_CA,
        S_DRAIN2
    } t_state;

    t_state r_state, n_state;
    logic [IW-1:0] r_i, n_i, r_j, n_j, r_k, n_k;
    logic [2:0] r_drain, n_drain;
    logic [tme_pkg::SIZE_W-1:0] r_size;
    logic r_strobe, r_kind, r_inrange, r_ovf;
    logic signed [31:0] r_ba;

    // storage
    logic signed [31:0] mem_a [tme_pkg::DEPTH];
    logic signed [31:0] mem_b [tme_pkg::DEPTH];
    logic signed [31:0] mem_s [tme_pkg::DEPTH];
    logic signed [31:0] mem_c [tme_pkg::DEPTH];
    logic signed [31:0] r_a0, r_a1, r_b, r_s, r_c;
    logic [AW-1:0] a0_addr, a1_addr, b_addr, s_addr, c_addr, wr_addr;

    tme_pkg::t_tag issue, r_tag1, mac_tag;
    logic signed [31:0] x, y, mac_acc, c_sum;
    logic mac_ovf, c_ovf;
    logic [IW-1:0] nm1;
    logic accept, cfg_wr, wr_ok;
    logic signed [32:0] c_wide;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & (paddr[2] == tme_pkg::REG_SIZE);
    assign prdata = (paddr[2] == tme_pkg::REG_SIZE) ? 32'(r_size) : 32'd0;

    // clamp size into 1..MAX_DIM, hold N-1
    always_comb begin
        if (r_size == '0) begin
            nm1 = '0;
        end else if (int'(r_size) > tme_pkg::MAX_DIM) begin
            nm1 = IW'(tme_pkg::MAX_DIM - 1);
        end else begin
            nm1 = IW'(r_size - 1'b1);
        end
    end

    assign busy   = (r_state != S_IDLE);
    assign accept = start & ~busy;
    assign wr_ok  = (int'(i_item.row) < tme_pkg::MAX_DIM) &&
                    (int'(i_item.col) < tme_pkg::MAX_DIM);
    assign wr_addr = tme_pkg::cell_addr(IW'(i_item.row), IW'(i_item.col));

    // issue one term per cycle while walking
    always_comb begin
        issue       = '0;
        issue.valid = (r_state == S_SQ) || (r_state == S_CB) || (r_state == S_CA);
        issue.i     = r_i;
        issue.j     = r_j;
        unique case (r_state)
            S_SQ: begin
                issue.kind  = tme_pkg::KIND_SQ;
                issue.first = (r_k == r_i);
                issue.last  = (r_k == r_j);
            end
            S_CB: begin
                issue.kind  = tme_pkg::KIND_BA;
                issue.first = (r_k == r_j);
                issue.last  = (r_k == nm1);
            end
            S_CA: begin
                issue.kind  = tme_pkg::KIND_AAB;
                issue.first = (r_k == r_i);
                issue.last  = (r_k == nm1);
            end
            default: begin
                issue.kind = tme_pkg::KIND_SQ;
            end
        endcase
    end

    assign a0_addr = (r_state == S_SQ) ? tme_pkg::cell_addr(r_i, r_k)
                                       : tme_pkg::cell_addr(r_j, r_k);
    assign a1_addr = tme_pkg::cell_addr(r_k, r_j);
    assign b_addr  = (r_state == S_CB) ? tme_pkg::cell_addr(r_i, r_k)
                                       : tme_pkg::cell_addr(r_k, r_j);
    assign s_addr  = tme_pkg::cell_addr(r_i, r_k);
    assign c_addr  = wr_addr;

    always_ff @(posedge i_clk) begin
        if (accept && wr_ok && i_item.command == tme_pkg::CMD_WRITE_A) begin
            mem_a[wr_addr] <= i_item.element_value;
        end
        r_a0 <= mem_a[a0_addr];
        r_a1 <= mem_a[a1_addr];
    end

    always_ff @(posedge i_clk) begin
        if (accept && wr_ok && i_item.command == tme_pkg::CMD_WRITE_B) begin
            mem_b[wr_addr] <= i_item.element_value;
        end
        r_b <= mem_b[b_addr];
    end

    always_ff @(posedge i_clk) begin
        if (mac_tag.valid && mac_tag.last && mac_tag.kind == tme_pkg::KIND_SQ) begin
            mem_s[tme_pkg::cell_addr(mac_tag.i, mac_tag.j)] <= mac_acc;
        end
        r_s <= mem_s[s_addr];
    end

    always_ff @(posedge i_clk) begin
        if (mac_tag.valid && mac_tag.last && mac_tag.kind == tme_pkg::KIND_AAB) begin
            mem_c[tme_pkg::cell_addr(mac_tag.i, mac_tag.j)] <= c_sum;
        end
        r_c <= mem_c[c_addr];
    end

    // route operands for the term now leaving the read stage
    always_comb begin
        case (r_tag1.kind)
            tme_pkg::KIND_SQ: begin
                x = r_a0;
                y = r_a1;
            end
            tme_pkg::KIND_BA: begin
                x = r_b;
                y = r_a0;
            end
            default: begin
                x = r_s;
                y = r_b;
            end
        endcase
    end

    tme_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_x     (x),
        .i_y     (y),
        .i_tag   (r_tag1),
        .o_acc   (mac_acc),
        .o_tag   (mac_tag),
        .o_ovf   (mac_ovf)
    );

    // final sum of the two partial products for one element of C
    assign c_wide = {r_ba[31], r_ba} + {mac_acc[31], mac_acc};
    assign c_sum  = tme_pkg::sat33(c_wide);
    assign c_ovf  = mac_tag.valid & mac_tag.last & (mac_tag.kind == tme_pkg::KIND_AAB) &
                    tme_pkg::ovf33(c_wide);

    // sequencer: advance loop counters
    always_comb begin
        n_state = r_state;
        n_i     = r_i;
        n_j     = r_j;
        n_k     = r_k;
        n_drain = r_drain;
        unique case (r_state)
            S_IDLE: begin
                if (accept && i_item.command == tme_pkg::CMD_COMPUTE) begin
                    n_state = S_SQ;
                    n_i = '0;
                    n_j = '0;
                    n_k = '0;
                end
            end
            S_SQ: begin
                if (r_k != r_j) begin
                    n_k = r_k + 1'b1;
                end else if (r_j != nm1) begin
                    n_j = r_j + 1'b1;
                    n_k = r_i;
                end else if (r_i != nm1) begin
                    n_i = r_i + 1'b1;
                    n_j = r_i + 1'b1;
                    n_k = r_i + 1'b1;
                end else begin
                    n_state = S_DRAIN1;
                    n_drain = '0;
                end
            end
            S_DRAIN1: begin
                n_drain = r_drain + 1'b1;
                if (r_drain == 3'd5) begin
                    n_state = S_CB;
                    n_i = '0;
                    n_j = '0;
                    n_k = '0;
                end
            end
            S_CB: begin
                if (r_k != nm1) begin
                    n_k = r_k + 1'b1;
                end else begin
                    n_state = S_CA;
                    n_k = r_i;
                end
            end
            S_CA: begin
                if (r_k != nm1) begin
                    n_k = r_k + 1'b1;
                end else if (r_j != nm1) begin
                    n_state = S_CB;
                    n_j = r_j + 1'b1;
                    n_k = r_j + 1'b1;
                end else if (r_i != nm1) begin
                    n_state = S_CB;
                    n_i = r_i + 1'b1;
                    n_j = '0;
                    n_k = '0;
                end else begin
                    n_state = S_DRAIN2;
                    n_drain = '0;
                end
            end
            S_DRAIN2: begin
                n_drain = r_drain + 1'b1;
                if (r_drain == 3'd5) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_i <= n_i;
        r_j <= n_j;
        r_k <= n_k;
        r_drain <= n_drain;
        if (mac_tag.valid && mac_tag.last && mac_tag.kind == tme_pkg::KIND_BA) begin
            r_ba <= mac_acc;
        end
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_size    <= tme_pkg::SIZE_RESET;
            r_strobe  <= 1'b0;
            r_kind    <= tme_pkg::RES_DONE;
            r_inrange <= 1'b0;
            r_ovf     <= 1'b0;
            r_tag1    <= '0;
        end else begin
            r_state <= n_state;
            r_tag1  <= issue;
            if (cfg_wr) begin
                r_size <= pwdata[tme_pkg::SIZE_W-1:0];
            end
            // clear the flag as a compute starts, set it on any clamp
            if (accept && i_item.command == tme_pkg::CMD_COMPUTE) begin
                r_ovf <= 1'b0;
            end else if (mac_ovf || c_ovf) begin
                r_ovf <= 1'b1;
            end
            r_strobe <= 1'b0;
            if (accept && i_item.command == tme_pkg::CMD_READ_C) begin
                r_strobe  <= 1'b1;
                r_kind    <= tme_pkg::RES_READ;
                r_inrange <= (int'(i_item.row) <= int'(nm1)) &&
                             (int'(i_item.col) <= int'(nm1));
            end else if (r_state == S_DRAIN2 && r_drain == 3'd5) begin
                r_strobe <= 1'b1;
                r_kind   <= tme_pkg::RES_DONE;
            end
        end
    end

    assign o_strobe                = r_strobe;
    assign o_result.result_kind    = r_kind;
    assign o_result.c_value        = (r_kind == tme_pkg::RES_READ && r_inrange) ? r_c : 32'sd0;
    assign o_result.overflow_seen  = r_ovf;

    a_compute_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_item.command == tme_pkg::CMD_COMPUTE) |=> busy)
        else $error("compute accepted but block not busy");

    a_done_after_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.result_kind == tme_pkg::RES_DONE) |->
        $past(r_state == S_DRAIN2))
        else $error("completion without draining the term pipeline");

    a_terms_in_compute: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mac_tag.valid |-> busy)
        else $error("term in flight while idle");

endmodule
